// ----- hw/rtl/tsf_pkg.sv -----
// Shared types and constants for the touch sample filter and averager.
`default_nettype none

package tsf_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned ERR_BITS   = 10;
  localparam int unsigned HIST_DEPTH = 3;
  localparam int unsigned CNT_BITS   = 2;

  localparam logic [ERR_BITS-1:0] DEV_MAX_RESET = ERR_BITS'(10);

  // Event codes.
  localparam logic [1:0] OP_TOUCH     = 2'd0;
  localparam logic [1:0] OP_CONV_DONE = 2'd1;
  localparam logic [1:0] OP_TIMER     = 2'd2;

  // Action codes.
  localparam logic [1:0] ACT_WAIT_DOWN = 2'd0;
  localparam logic [1:0] ACT_MEASURE   = 2'd1;
  localparam logic [1:0] ACT_WAIT_UP   = 2'd2;

  localparam logic [CNT_BITS-1:0] LAST_HIST_IDX = CNT_BITS'(HIST_DEPTH - 1);

  typedef logic [HIST_DEPTH-1:0][COORD_BITS-1:0] hist_t;

  typedef struct packed {
    logic [1:0]            opcode;
    logic                  pen_up;
    logic [COORD_BITS-1:0] x_sample;
    logic [COORD_BITS-1:0] y_sample;
  } in_t;

  typedef struct packed {
    logic [1:0]            action;
    logic                  point_valid;
    logic [COORD_BITS-1:0] x_point;
    logic [COORD_BITS-1:0] y_point;
  } out_t;

  typedef struct packed {
    logic                  ok;
    logic [COORD_BITS-1:0] avg;
  } axis_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tsf_axis.sv -----
// Outlier check and four-sample average for one coordinate axis.
`default_nettype none

module tsf_axis (
  input  tsf_pkg::hist_t                    hist_i,
  input  logic [tsf_pkg::COORD_BITS-1:0]    sample_i,
  input  logic [tsf_pkg::ERR_BITS-1:0]      dev_max_i,
  output tsf_pkg::axis_res_t                res_o
);

  localparam int unsigned CB = tsf_pkg::COORD_BITS;

  // A sample passes when its distance to the floor mean of the two before it
  // does not exceed the limit.
  function automatic logic dev_ok(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                  input logic [CB-1:0] s,
                                  input logic [tsf_pkg::ERR_BITS-1:0] lim);
    logic [CB:0]   sum;
    logic [CB-1:0] mean;
    logic [CB-1:0] dev;
    sum  = {1'b0, a} + {1'b0, b};
    mean = sum[CB:1];
    dev  = (s > mean) ? (s - mean) : (mean - s);
    return dev <= lim;
  endfunction

  logic [CB+1:0] total;

  assign total = {2'b00, hist_i[0]} + {2'b00, hist_i[1]} + {2'b00, hist_i[2]}
               + {2'b00, sample_i};

  assign res_o.ok  = dev_ok(hist_i[0], hist_i[1], hist_i[2], dev_max_i)
                   & dev_ok(hist_i[1], hist_i[2], sample_i, dev_max_i);
  assign res_o.avg = total[CB+1:2];

endmodule

`default_nettype wire

// ----- hw/rtl/touch_sample_filter_average.sv -----
// Top level: touch event sequencer with four-sample outlier filter.
//
//   Channel  Signals                          Direction  Payload
//   in       in_valid_i / in_ready_o          input      tsf_pkg::in_t
//   out      out_valid_o / out_ready_i        output     tsf_pkg::out_t
//   cfg      cfg_we_i / cfg_wdata_i           input      deviation limit (10 bits)
//
// Every event produces exactly one result. The event waits in the input register
// until the output register is free, and its result is then registered there.
// One event per cycle is sustained while out_ready_i stays high: an input
// register feeds the decision logic, whose result lands in the output register.
// The input register keeps taking events while a result waits in the output
// register; only when both are full does in_ready_o drop.
// Reset clears the sample count and sets the deviation limit to 10.
`default_nettype none

module touch_sample_filter_average (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tsf_pkg::ERR_BITS-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tsf_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tsf_pkg::out_t                  out_data_o
);

  logic [tsf_pkg::ERR_BITS-1:0] dev_max_q;
  logic                         s1_valid_q, s1_valid_d;
  tsf_pkg::in_t                 s1_data_q;
  logic                         out_valid_q, out_valid_d;
  tsf_pkg::out_t                out_data_q, out_data_d;
  logic [tsf_pkg::CNT_BITS-1:0] sample_count_q, sample_count_d;
  tsf_pkg::hist_t               x_hist_q, y_hist_q;
  logic                         hist_we;
  logic                         in_xfer, advance;
  tsf_pkg::axis_res_t           x_res, y_res;

  assign advance    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | advance;
  assign in_xfer    = in_valid_i & in_ready_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  tsf_axis u_x_axis (
    .hist_i      (x_hist_q),
    .sample_i    (s1_data_q.x_sample),
    .dev_max_i   (dev_max_q),
    .res_o       (x_res)
  );

  tsf_axis u_y_axis (
    .hist_i      (y_hist_q),
    .sample_i    (s1_data_q.y_sample),
    .dev_max_i   (dev_max_q),
    .res_o       (y_res)
  );

  always_comb begin
    sample_count_d = sample_count_q;
    hist_we        = 1'b0;
    out_data_d     = '0;
    if (s1_data_q.opcode != tsf_pkg::OP_CONV_DONE) begin
      // Touch change, timer expiry and the unused code only look at the pen.
      out_data_d.action = s1_data_q.pen_up ? tsf_pkg::ACT_WAIT_DOWN
                                           : tsf_pkg::ACT_MEASURE;
    end else if (s1_data_q.pen_up) begin
      sample_count_d    = '0;
      out_data_d.action = tsf_pkg::ACT_WAIT_DOWN;
    end else if (sample_count_q < tsf_pkg::CNT_BITS'(tsf_pkg::HIST_DEPTH)) begin
      hist_we           = 1'b1;
      sample_count_d    = sample_count_q + 1'b1;
      out_data_d.action = tsf_pkg::ACT_MEASURE;
    end else begin
      sample_count_d    = '0;
      out_data_d.action = tsf_pkg::ACT_WAIT_UP;
      if (x_res.ok && y_res.ok) begin
        out_data_d.point_valid = 1'b1;
        out_data_d.x_point     = x_res.avg;
        out_data_d.y_point     = y_res.avg;
      end
    end
  end

  always_comb begin
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_max_q      <= tsf_pkg::DEV_MAX_RESET;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      sample_count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        dev_max_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        sample_count_q <= sample_count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
    // The count stays below the depth whenever a sample is stored here.
    if (advance && hist_we) begin
      x_hist_q[sample_count_q] <= s1_data_q.x_sample;
      y_hist_q[sample_count_q] <= s1_data_q.y_sample;
    end
  end

  a_point_only_on_wait_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.point_valid |-> out_data_q.action == tsf_pkg::ACT_WAIT_UP)
    else $error("point reported without wait-pen-up action");

  a_no_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.point_valid |->
      out_data_q.x_point == '0 && out_data_q.y_point == '0)
    else $error("nonzero coordinates without a point");

  a_pen_up_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_data_q.opcode == tsf_pkg::OP_CONV_DONE && s1_data_q.pen_up
      |=> sample_count_q == '0)
    else $error("sample count not cleared on pen-up conversion");

  a_pen_event_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_data_q.opcode != tsf_pkg::OP_CONV_DONE |=> $stable(sample_count_q))
    else $error("pen event changed the sample count");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q)
    else $error("input stage dropped an event");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |-> sample_count_q <= tsf_pkg::LAST_HIST_IDX)
    else $error("history write beyond depth");

endmodule

`default_nettype wire

// ----- verif/tb_touch_sample_filter_average.sv -----
// Testbench for the touch sample filter: a directed table, then checked random bursts.
module tb_touch_sample_filter_average;

  // Event code that the block has no use for; it must act like a pen event.
  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam int unsigned STALL_PCT   = 19;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_LEN   = 150;
  localparam int          CMAX        = (1 << tsf_pkg::COORD_BITS) - 1;

  typedef struct {
    tsf_pkg::in_t  ev;
    bit            known;
    tsf_pkg::out_t res;
  } row_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [tsf_pkg::ERR_BITS-1:0]  cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  tsf_pkg::in_t                  in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  tsf_pkg::out_t                 out_data_o;

  // Predictor state.
  logic [tsf_pkg::ERR_BITS-1:0]   err_lim   = tsf_pkg::DEV_MAX_RESET;
  logic [tsf_pkg::CNT_BITS-1:0]   burst_cnt = '0;
  logic [tsf_pkg::COORD_BITS-1:0] x_hist [tsf_pkg::HIST_DEPTH];
  logic [tsf_pkg::COORD_BITS-1:0] y_hist [tsf_pkg::HIST_DEPTH];

  tsf_pkg::out_t outcome_q [$];
  row_t rows [$];
  int   n_bad   = 0;
  int   quiet   = 0;
  bit   no_idle = 1'b0;

  touch_sample_filter_average i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic tsf_pkg::in_t ev_of(logic [1:0] op, logic pen, int x, int y);
    tsf_pkg::in_t ev;
    ev.opcode   = op;
    ev.pen_up   = pen;
    ev.x_sample = tsf_pkg::COORD_BITS'(x);
    ev.y_sample = tsf_pkg::COORD_BITS'(y);
    return ev;
  endfunction

  function automatic tsf_pkg::out_t res_of(logic [1:0] act, logic ok, int x, int y);
    tsf_pkg::out_t r;
    r.action      = act;
    r.point_valid = ok;
    r.x_point     = tsf_pkg::COORD_BITS'(x);
    r.y_point     = tsf_pkg::COORD_BITS'(y);
    return r;
  endfunction

  function automatic row_t row(tsf_pkg::in_t ev, bit known, tsf_pkg::out_t res);
    row_t r;
    r.ev    = ev;
    r.known = known;
    r.res   = res;
    return r;
  endfunction

  function automatic bit near_mean(logic [tsf_pkg::COORD_BITS-1:0] a,
                                   logic [tsf_pkg::COORD_BITS-1:0] b,
                                   logic [tsf_pkg::COORD_BITS-1:0] s);
    int mean;
    int dev;
    mean = (int'(a) + int'(b)) >> 1;
    dev  = (int'(s) > mean) ? int'(s) - mean : mean - int'(s);
    return dev <= int'(err_lim);
  endfunction

  // Works out the action for one event and advances the burst state.
  function automatic tsf_pkg::out_t sequence_event(tsf_pkg::in_t ev);
    tsf_pkg::out_t r;
    int            xsum;
    int            ysum;
    r = '0;
    if (ev.opcode != tsf_pkg::OP_CONV_DONE) begin
      r.action = ev.pen_up ? tsf_pkg::ACT_WAIT_DOWN : tsf_pkg::ACT_MEASURE;
    end else if (ev.pen_up) begin
      burst_cnt = '0;
      r.action  = tsf_pkg::ACT_WAIT_DOWN;
    end else if (burst_cnt <= tsf_pkg::LAST_HIST_IDX) begin
      x_hist[burst_cnt] = ev.x_sample;
      y_hist[burst_cnt] = ev.y_sample;
      burst_cnt++;
      r.action = tsf_pkg::ACT_MEASURE;
    end else begin
      r.action = tsf_pkg::ACT_WAIT_UP;
      if (near_mean(x_hist[0], x_hist[1], x_hist[2]) &&
          near_mean(x_hist[1], x_hist[2], ev.x_sample) &&
          near_mean(y_hist[0], y_hist[1], y_hist[2]) &&
          near_mean(y_hist[1], y_hist[2], ev.y_sample)) begin
        xsum = int'(x_hist[0]) + int'(x_hist[1]) + int'(x_hist[2]) + int'(ev.x_sample);
        ysum = int'(y_hist[0]) + int'(y_hist[1]) + int'(y_hist[2]) + int'(ev.y_sample);
        r.point_valid = 1'b1;
        r.x_point     = tsf_pkg::COORD_BITS'(xsum >> 2);
        r.y_point     = tsf_pkg::COORD_BITS'(ysum >> 2);
      end
      burst_cnt = '0;
    end
    return r;
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > CMAX) ? CMAX : v;
  endfunction

  // Four samples of one axis; samples 3 and 4 land inside, on, or just past the
  // deviation limit, with an occasional wild outlier.
  function automatic logic [3:0][tsf_pkg::COORD_BITS-1:0] make_track();
    int s [4];
    int m;
    int off;
    int lim;
    logic [3:0][tsf_pkg::COORD_BITS-1:0] t;
    lim  = int'(err_lim);
    s[0] = $urandom_range(CMAX);
    s[1] = clamp_coord(s[0] + int'($urandom_range(128)) - 64);
    for (int k = 2; k < 4; k++) begin
      m = (s[k-2] + s[k-1]) >> 1;
      case ($urandom_range(9))
        8, 9:    off = int'($urandom_range(CMAX)) - CMAX / 2;
        7:       off = $urandom_range(1) ? lim + 1 : -(lim + 1);
        6:       off = $urandom_range(1) ? lim : -lim;
        default: off = int'($urandom_range(2 * lim)) - lim;
      endcase
      s[k] = clamp_coord(m + off);
    end
    for (int k = 0; k < 4; k++) t[k] = tsf_pkg::COORD_BITS'(s[k]);
    return t;
  endfunction

  function automatic tsf_pkg::in_t pen_event();
    logic [1:0] op;
    case ($urandom_range(2))
      0:       op = tsf_pkg::OP_TOUCH;
      1:       op = tsf_pkg::OP_TIMER;
      default: op = OP_SPARE;
    endcase
    return ev_of(op, 1'($urandom_range(1)), $urandom_range(CMAX), $urandom_range(CMAX));
  endfunction

  task automatic send_event(tsf_pkg::in_t ev, bit known = 1'b0, tsf_pkg::out_t res = '0);
    tsf_pkg::out_t predicted;
    while (!no_idle && $urandom_range(99) < STALL_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = sequence_event(ev);
    outcome_q.push_back(known ? res : predicted);
  endtask

  // Only written with nothing in flight.
  task automatic write_limit(logic [tsf_pkg::ERR_BITS-1:0] v);
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    err_lim   = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int n);
    int sent;
    int pick;
    logic [3:0][tsf_pkg::COORD_BITS-1:0] xt;
    logic [3:0][tsf_pkg::COORD_BITS-1:0] yt;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // Lift the pen first so that most bursts start from an empty count.
        if (burst_cnt != 0 && $urandom_range(3) != 0) begin
          send_event(ev_of(tsf_pkg::OP_CONV_DONE, 1'b1,
                           $urandom_range(CMAX), $urandom_range(CMAX)));
          sent++;
        end
        xt = make_track();
        yt = make_track();
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(7) == 0) begin
            send_event(pen_event());
            sent++;
          end
          if ($urandom_range(24) == 0) begin
            send_event(ev_of(tsf_pkg::OP_CONV_DONE, 1'b1, int'(xt[k]), int'(yt[k])));
            sent++;
            break;
          end
          send_event(ev_of(tsf_pkg::OP_CONV_DONE, 1'b0, int'(xt[k]), int'(yt[k])));
          sent++;
        end
      end else if (pick < 85) begin
        send_event(pen_event());
        sent++;
      end else begin
        send_event(ev_of(2'($urandom_range(3)), 1'($urandom_range(1)),
                         $urandom_range(CMAX), $urandom_range(CMAX)));
        sent++;
      end
    end
  endtask

  task automatic check_result(tsf_pkg::out_t got);
    tsf_pkg::out_t want;
    if (outcome_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("unexpected result: act=%0d valid=%0d x=%0d y=%0d",
                 got.action, got.point_valid, got.x_point, got.y_point);
      return;
    end
    want = outcome_q.pop_front();
    if (got.action !== want.action || got.point_valid !== want.point_valid ||
        got.x_point !== want.x_point || got.y_point !== want.y_point) begin
      n_bad++;
      if (n_bad <= 10)
        $display({"mismatch: expected act=%0d valid=%0d x=%0d y=%0d, ",
                  "got act=%0d valid=%0d x=%0d y=%0d"},
                 want.action, want.point_valid, want.x_point, want.y_point,
                 got.action, got.point_valid, got.x_point, got.y_point);
    end
  endtask

  // Result checking, output stalls and the watchdog on transfers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
    out_ready_i <= no_idle || ($urandom_range(99) >= STALL_PCT);
  end

  initial begin
    logic [tsf_pkg::ERR_BITS-1:0] lim;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pen events for every event code, under the reset value of the limit.
    rows.push_back(row(ev_of(tsf_pkg::OP_TOUCH, 1'b1, 0, 0), 1'b1,
                       res_of(tsf_pkg::ACT_WAIT_DOWN, 1'b0, 0, 0)));
    rows.push_back(row(ev_of(tsf_pkg::OP_TOUCH, 1'b0, CMAX, CMAX), 1'b1,
                       res_of(tsf_pkg::ACT_MEASURE, 1'b0, 0, 0)));
    rows.push_back(row(ev_of(tsf_pkg::OP_TIMER, 1'b1, CMAX, 0), 1'b1,
                       res_of(tsf_pkg::ACT_WAIT_DOWN, 1'b0, 0, 0)));
    rows.push_back(row(ev_of(tsf_pkg::OP_TIMER, 1'b0, 0, CMAX), 1'b1,
                       res_of(tsf_pkg::ACT_MEASURE, 1'b0, 0, 0)));
    rows.push_back(row(ev_of(OP_SPARE, 1'b1, 0, 0), 1'b1,
                       res_of(tsf_pkg::ACT_WAIT_DOWN, 1'b0, 0, 0)));
    rows.push_back(row(ev_of(OP_SPARE, 1'b0, CMAX, CMAX), 1'b1,
                       res_of(tsf_pkg::ACT_MEASURE, 1'b0, 0, 0)));
    rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b1, 5, 6), 1'b1,
                       res_of(tsf_pkg::ACT_WAIT_DOWN, 1'b0, 0, 0)));
    // A full-scale burst, an all-zero burst and one with an outlier in x.
    for (int k = 0; k < 3; k++)
      rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b0, CMAX, CMAX), 1'b1,
                         res_of(tsf_pkg::ACT_MEASURE, 1'b0, 0, 0)));
    rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b0, CMAX, CMAX), 1'b1,
                       res_of(tsf_pkg::ACT_WAIT_UP, 1'b1, CMAX, CMAX)));
    for (int k = 0; k < 3; k++)
      rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b0, 0, 0), 1'b1,
                         res_of(tsf_pkg::ACT_MEASURE, 1'b0, 0, 0)));
    rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b0, 0, 0), 1'b1,
                       res_of(tsf_pkg::ACT_WAIT_UP, 1'b1, 0, 0)));
    for (int k = 0; k < 3; k++)
      rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b0, 100, 100), 1'b1,
                         res_of(tsf_pkg::ACT_MEASURE, 1'b0, 0, 0)));
    rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b0, 500, 100), 1'b1,
                       res_of(tsf_pkg::ACT_WAIT_UP, 1'b0, 0, 0)));
    // A burst cut short by the pen lifting, then one that sits on the limit
    // with a pen event in the middle of it.
    rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b0, 7, 9), 1'b0, '0));
    rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b1, 7, 9), 1'b1,
                       res_of(tsf_pkg::ACT_WAIT_DOWN, 1'b0, 0, 0)));
    rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b0, 10, 1000), 1'b0, '0));
    rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b0, 20, 990), 1'b0, '0));
    rows.push_back(row(ev_of(tsf_pkg::OP_TIMER, 1'b0, 3, 4), 1'b0, '0));
    rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b0, 25, 995), 1'b0, '0));
    rows.push_back(row(ev_of(tsf_pkg::OP_CONV_DONE, 1'b0, 23, 1002), 1'b0, '0));

    foreach (rows[i]) send_event(rows[i].ev, rows[i].known, rows[i].res);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       lim = tsf_pkg::ERR_BITS'(CMAX);
        1:       lim = '0;
        2:       lim = tsf_pkg::ERR_BITS'(1);
        3:       lim = tsf_pkg::DEV_MAX_RESET;
        4:       lim = tsf_pkg::ERR_BITS'(37);
        5:       lim = tsf_pkg::ERR_BITS'(3);
        default: lim = tsf_pkg::ERR_BITS'($urandom_range(CMAX));
      endcase
      write_limit(lim);
      // One phase runs at full rate on both sides.
      no_idle = (p == 3);
      run_phase(PHASE_LEN);
    end

    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- touch_sample_filter_average.f -----
hw/rtl/tsf_pkg.sv
hw/rtl/tsf_axis.sv
hw/rtl/touch_sample_filter_average.sv
verif/tb_touch_sample_filter_average.sv
